// ===== design/sha1sh_pkg.sv =====
// Shared types and constants for the SHA-1 stream hasher.
// Used by sha1sh_core and sha1_stream_hasher_top; no dependencies.
package sha1sh_pkg;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam int unsigned CHAIN_DEPTH = 5;
    localparam int unsigned BUF_DEPTH   = 16;

    // Control from the sequencer to the round datapath
    typedef struct packed {
        logic       load;      // capture chaining word into working reg idx
        logic [2:0] idx;       // working register select (a..e)
        logic       rnd;       // run one compression round
        logic [6:0] t;         // round number
    } core_ctrl_t;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/sha1sh_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sha1sh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sha1sh_core.sv =====
// SHA-1 round datapath: working registers a..e and the 16-word schedule window.
// Depends on sha1sh_pkg.
module sha1sh_core (
    input  logic                   aclk,
    input  sha1sh_pkg::core_ctrl_t ctrl,
    input  logic [31:0]            load_data,
    input  logic [31:0]            buf_data,
    output logic [31:0]            var_word
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [0:15];
    logic [31:0] sched, wt, f, k, x, tmp;

    always_comb begin
        x     = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        sched = {x[30:0], x[31]};
        wt    = (ctrl.t < 7'd16) ? buf_data : sched;
        if (ctrl.t < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1sh_pkg::K0;
        end else if (ctrl.t < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1sh_pkg::K1;
        end else if (ctrl.t < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1sh_pkg::K2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1sh_pkg::K3;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;
    end

    always_comb begin
        case (ctrl.idx)
            3'd0:    var_word = a_reg;
            3'd1:    var_word = b_reg;
            3'd2:    var_word = c_reg;
            3'd3:    var_word = d_reg;
            default: var_word = e_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            case (ctrl.idx)
                3'd0:    a_reg <= load_data;
                3'd1:    b_reg <= load_data;
                3'd2:    c_reg <= load_data;
                3'd3:    d_reg <= load_data;
                default: e_reg <= load_data;
            endcase
        end else if (ctrl.rnd) begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // schedule window: w_reg[0] is W[t-16], w_reg[15] is W[t-1]
    always_ff @(posedge aclk) begin
        if (ctrl.rnd) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wt;
        end
    end

endmodule

// ===== design/sha1_stream_hasher_top.sv =====
// SHA-1 stream hasher top: byte packing, padding sequencer, chain and block RAMs.
// Depends on sha1sh_pkg, sha1sh_ram, sha1sh_core.
// Throughput: bytes are accepted one per cycle while idle; the 64th byte of a block starts
// compression (chain reads, 80 rounds at one per cycle, then the chain update through the RAM).
// Finish: 16 - pos/4 padding writes, then compression; 56 or more bytes pending add a second
// padded block. The five digest words come out during the final chain update, which waits
// while the output register is held. Reset (synchronous, active low) starts a pass writing
// the initial chain values, with no item taken; state also returns to reset after a digest.
module sha1_stream_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_CHRD = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_ARD  = 3'd5;
    localparam logic [2:0] S_AWR  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  t_reg, t_next;
    logic [3:0]  widx_reg, widx_next;
    logic        first_reg, first_next;
    logic        len_here_reg, len_here_next;
    logic        fin_reg, fin_next;
    logic        final_reg, final_next;
    logic [63:0] count_reg, count_next;
    logic [31:0] word_reg, word_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_word_reg, m_word_next;
    logic [2:0]  m_idx_reg, m_idx_next;
    logic        m_last_reg, m_last_next;

    logic        s_accept;
    logic [5:0]  pos;
    logic [31:0] byte_word, pad_word, sum;

    logic        buf_we;
    logic [3:0]  buf_waddr, buf_raddr;
    logic [31:0] buf_wdata, buf_rdata;
    logic        ch_we;
    logic [2:0]  ch_waddr, ch_raddr;
    logic [31:0] ch_wdata, ch_rdata;
    logic [31:0] var_word;
    sha1sh_pkg::core_ctrl_t ctrl;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign pos      = count_reg[5:0];
    assign sum      = ch_rdata + var_word;

    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_word_reg;
    assign m_word_index  = m_idx_reg;
    assign m_last_word   = m_last_reg;

    // Assemble the current big-endian word; bytes below the new one stay zero
    always_comb begin
        byte_word = word_reg;
        case (pos[1:0])
            2'd0:    byte_word = {s_data_byte, 24'd0};
            2'd1:    byte_word[23:16] = s_data_byte;
            2'd2:    byte_word[15:8]  = s_data_byte;
            default: byte_word[7:0]   = s_data_byte;
        endcase
        pad_word = word_reg;
        case (pos[1:0])
            2'd0:    pad_word = 32'h8000_0000;
            2'd1:    pad_word[23:16] = 8'h80;
            2'd2:    pad_word[15:8]  = 8'h80;
            default: pad_word[7:0]   = 8'h80;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        t_next        = t_reg;
        widx_next     = widx_reg;
        first_next    = first_reg;
        len_here_next = len_here_reg;
        fin_next      = fin_reg;
        final_next    = final_reg;
        count_next    = count_reg;
        word_next     = word_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_word_next   = m_word_reg;
        m_idx_next    = m_idx_reg;
        m_last_next   = m_last_reg;

        buf_we    = 1'b0;
        buf_waddr = widx_reg;
        buf_wdata = 32'd0;
        buf_raddr = 4'd0;
        ch_we     = 1'b0;
        ch_waddr  = cnt_reg;
        ch_wdata  = sum;
        ch_raddr  = cnt_reg;
        ctrl.load = 1'b0;
        ctrl.idx  = cnt_reg;
        ctrl.rnd  = 1'b0;
        ctrl.t    = t_reg;

        unique case (state_reg)
            S_INIT: begin
                ch_we    = 1'b1;
                ch_wdata = sha1sh_pkg::iv_word(cnt_reg);
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    if (s_op == sha1sh_pkg::OP_APPEND) begin
                        word_next  = byte_word;
                        buf_we     = (pos[1:0] == 2'd3);
                        buf_waddr  = pos[5:2];
                        buf_wdata  = byte_word;
                        count_next = count_reg + 64'd1;
                        if (pos == 6'h3F) begin
                            state_next = S_CHRD;
                            cnt_next   = 3'd0;
                            final_next = 1'b0;
                            fin_next   = 1'b0;
                        end
                    end else begin
                        state_next    = S_PAD;
                        widx_next     = pos[5:2];
                        first_next    = 1'b1;
                        len_here_next = (pos < 6'd56);
                        fin_next      = 1'b1;
                    end
                end
            end
            S_PAD: begin
                buf_we = 1'b1;
                if (first_reg) begin
                    buf_wdata = pad_word;
                end else if (len_here_reg && widx_reg == 4'd14) begin
                    buf_wdata = count_reg[60:29];
                end else if (len_here_reg && widx_reg == 4'd15) begin
                    buf_wdata = {count_reg[28:0], 3'd0};
                end
                first_next = 1'b0;
                widx_next  = widx_reg + 4'd1;
                if (widx_reg == 4'd15) begin
                    state_next = S_CHRD;
                    cnt_next   = 3'd0;
                    final_next = len_here_reg;
                end
            end
            S_CHRD: begin
                ctrl.load = (cnt_reg != 3'd0);
                ctrl.idx  = cnt_reg - 3'd1;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    buf_raddr  = 4'd0;
                    state_next = S_RND;
                    t_next     = 7'd0;
                end
            end
            S_RND: begin
                ctrl.rnd  = 1'b1;
                buf_raddr = t_reg[3:0] + 4'd1;
                t_next    = t_reg + 7'd1;
                if (t_reg == 7'd79) begin
                    state_next = S_ARD;
                    cnt_next   = 3'd0;
                end
            end
            S_ARD: begin
                // a digest word may only be produced once the output register frees up
                if (!(final_reg && m_valid_reg && !m_ready)) begin
                    state_next = S_AWR;
                end
            end
            S_AWR: begin
                ch_we = 1'b1;
                if (final_reg) begin
                    ch_wdata     = sha1sh_pkg::iv_word(cnt_reg);
                    m_valid_next = 1'b1;
                    m_word_next  = sum;
                    m_idx_next   = cnt_reg;
                    m_last_next  = (cnt_reg == 3'd4);
                end
                cnt_next   = cnt_reg + 3'd1;
                state_next = S_ARD;
                if (cnt_reg == 3'd4) begin
                    if (final_reg) begin
                        state_next = S_IDLE;
                        count_next = 64'd0;
                        fin_next   = 1'b0;
                        final_next = 1'b0;
                    end else if (fin_reg) begin
                        // second padded block carries only zeros and the length
                        state_next    = S_PAD;
                        widx_next     = 4'd0;
                        first_next    = 1'b0;
                        len_here_next = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_INIT;
                cnt_next   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            cnt_reg      <= 3'd0;
            t_reg        <= 7'd0;
            widx_reg     <= 4'd0;
            first_reg    <= 1'b0;
            len_here_reg <= 1'b0;
            fin_reg      <= 1'b0;
            final_reg    <= 1'b0;
            count_reg    <= 64'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            t_reg        <= t_next;
            widx_reg     <= widx_next;
            first_reg    <= first_next;
            len_here_reg <= len_here_next;
            fin_reg      <= fin_next;
            final_reg    <= final_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        m_word_reg <= m_word_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
    end

    sha1sh_ram #(
        .WIDTH (32),
        .DEPTH (sha1sh_pkg::BUF_DEPTH)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    sha1sh_ram #(
        .WIDTH (32),
        .DEPTH (sha1sh_pkg::CHAIN_DEPTH)
    ) u_chain_ram (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    sha1sh_core u_core (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .load_data (ch_rdata),
        .buf_data  (buf_rdata),
        .var_word  (var_word)
    );

endmodule
